// ===== hdl/ldpc_min_sum_check_node_top_macros.svh =====
// assertion helpers for the check-node unit
`ifndef LDPC_MIN_SUM_CHECK_NODE_TOP_MACROS_SVH
`define LDPC_MIN_SUM_CHECK_NODE_TOP_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define LCN_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("check node assertion failed");

// next-cycle implication, checked on every clock outside reset
`define LCN_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("check node assertion failed");

`endif

// ===== hdl/ldpc_cn_pkg.sv =====
package ldpc_cn_pkg;

    // default sizing
    localparam int MAX_DEGREE_DEF = 8;
    localparam int MSG_WIDTH_DEF  = 8;

    // configuration field widths
    localparam int MODE_W     = 2;
    localparam int NORM_W     = 8;
    localparam int OFF_W      = 7;
    localparam int DEG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration reset values
    localparam logic [MODE_W-1:0] MODE_RST   = 2'd0;
    localparam logic [NORM_W-1:0] NORM_RST   = 8'd154;
    localparam logic [OFF_W-1:0]  OFF_RST    = 7'd4;
    localparam logic [DEG_W-1:0]  DEG_RST    = 4'd8;
    localparam logic [DEG_W-1:0]  DEG_MIN    = 4'd2;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_NORM   = 2'd1,
        REG_OFFSET = 2'd2,
        REG_DEGREE = 2'd3
    } cfg_reg_t;

    // check-node modes, code 3 behaves as plain
    typedef enum logic [MODE_W-1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_NORM   = 2'd1,
        MODE_OFFSET = 2'd2
    } cnu_mode_t;

    // magnitude correction settings
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NORM_W-1:0] norm_factor;
        logic [OFF_W-1:0]  offset_value;
    } cnu_cfg_t;

endpackage

// ===== hdl/ldpc_min_sum_check_node_top.sv =====
// LDPC min-sum check-node unit.
// Input channel s_*: one check row per transaction, MAX_DEGREE signed messages
// packed in s_tdata, lane 0 in the lowest bits. Output channel m_*: the
// check-to-variable messages in the same packing; lanes at or beyond the
// active degree carry zero.
// Configuration channel cfg_*: register index and data, always ready; writes
// are expected only while no row is in flight.
// Pipeline stages, from s_ transaction to m_tvalid: lane magnitudes,
// min/second-min merge tree, magnitude correction (one 7x8 multiply),
// output sign and lane select. Throughput is one row per cycle while m_tready
// is high; the four pipeline registers each advance whenever the register
// after them is empty or moving.
// When m_tready is low the output holds and bubbles upstream are squeezed out,
// so up to four rows are held before s_tready drops.
// Synchronous active-low reset empties the pipeline and returns the
// registers to plain mode, factor 154, offset 4, degree 8.
`include "ldpc_min_sum_check_node_top_macros.svh"

module ldpc_min_sum_check_node_top
    import ldpc_cn_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int MSG_WIDTH  = MSG_WIDTH_DEF,
    localparam int TDATA_W   = ((MAX_DEGREE * MSG_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // msg_0 .. msg_(MAX_DEGREE-1), then zero fill
    input  logic [TDATA_W-1:0]    s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // c2v_0 .. c2v_(MAX_DEGREE-1), then zero fill
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int IDX_W  = $clog2(MAX_DEGREE);
    localparam int MAG_W  = MSG_WIDTH - 1;
    localparam int USED_W = MAX_DEGREE * MSG_WIDTH;
    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_DEGREE);

    // configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [NORM_W-1:0] norm_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [DEG_W-1:0]  deg_reg;
    logic [DEG_W-1:0]  deg_eff;
    cnu_cfg_t          cfg;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1: lane magnitudes
    logic signed [MSG_WIDTH-1:0] msg      [MAX_DEGREE];
    logic        [MSG_WIDTH-1:0] mag_next [MAX_DEGREE];
    logic        [MSG_WIDTH-1:0] mag_reg  [MAX_DEGREE];
    logic [MAX_DEGREE-1:0] act_next, act1_reg;
    logic [MAX_DEGREE-1:0] neg_next, neg1_reg;

    // stage 2: merged minima
    logic [MAG_W-1:0]      min0_next, min1_next, min0_reg, min1_reg;
    logic [IDX_W-1:0]      idx_next, idx2_reg;
    logic [MAX_DEGREE-1:0] sgn2_reg, act2_reg;
    logic                  parity;

    // stage 3: corrected minima
    logic [MAG_W-1:0]      amin0_next, amin1_next, amin0_reg, amin1_reg;
    logic [IDX_W-1:0]      idx3_reg;
    logic [MAX_DEGREE-1:0] sgn3_reg, act3_reg;

    // stage 4: output word
    logic [TDATA_W-1:0]    tdata_next, tdata_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RST;
            norm_reg <= NORM_RST;
            off_reg  <= OFF_RST;
            deg_reg  <= DEG_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE:   mode_reg <= cfg_data[MODE_W-1:0];
                REG_NORM:   norm_reg <= cfg_data[NORM_W-1:0];
                REG_OFFSET: off_reg  <= cfg_data[OFF_W-1:0];
                REG_DEGREE: deg_reg  <= cfg_data[DEG_W-1:0];
                default: ;
            endcase
        end
    end

    // degree clamped to the supported lane range
    always_comb begin
        if (deg_reg < DEG_MIN) begin
            deg_eff = DEG_MIN;
        end else if (deg_reg > DEG_MAX) begin
            deg_eff = DEG_MAX;
        end else begin
            deg_eff = deg_reg;
        end
    end

    assign cfg.mode         = mode_reg;
    assign cfg.norm_factor  = norm_reg;
    assign cfg.offset_value = off_reg;

    // stall chain, each stage moves when the next one frees up
    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // lane magnitude and sign
    for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_lane
        assign msg[i]      = s_tdata[i*MSG_WIDTH +: MSG_WIDTH];
        assign act_next[i] = DEG_W'(i) < deg_eff;

        ldpc_cn_lane #(
            .MSG_WIDTH (MSG_WIDTH)
        ) u_lane (
            .msg    (msg[i]),
            .active (act_next[i]),
            .mag    (mag_next[i]),
            .neg    (neg_next[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            mag_reg  <= mag_next;
            neg1_reg <= neg_next;
            act1_reg <= act_next;
        end
    end

    // minimum, second minimum and the lane of the minimum
    ldpc_cn_merge #(
        .MAX_DEGREE (MAX_DEGREE),
        .MSG_WIDTH  (MSG_WIDTH)
    ) u_merge (
        .mag  (mag_reg),
        .min0 (min0_next),
        .min1 (min1_next),
        .idx  (idx_next)
    );

    assign parity = ^neg1_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            min0_reg <= min0_next;
            min1_reg <= min1_next;
            idx2_reg <= idx_next;
            sgn2_reg <= neg1_reg ^ {MAX_DEGREE{parity}};
            act2_reg <= act1_reg;
        end
    end

    // mode-dependent magnitude correction
    ldpc_cn_adjust #(
        .MSG_WIDTH (MSG_WIDTH)
    ) u_adjust0 (
        .cfg     (cfg),
        .mag_in  (min0_reg),
        .mag_out (amin0_next)
    );

    ldpc_cn_adjust #(
        .MSG_WIDTH (MSG_WIDTH)
    ) u_adjust1 (
        .cfg     (cfg),
        .mag_in  (min1_reg),
        .mag_out (amin1_next)
    );

    always_ff @(posedge aclk) begin
        if (en3) begin
            amin0_reg <= amin0_next;
            amin1_reg <= amin1_next;
            idx3_reg  <= idx2_reg;
            sgn3_reg  <= sgn2_reg;
            act3_reg  <= act2_reg;
        end
    end

    // per-lane output: other minimum, signed by the parity without its own sign
    for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_out
        logic [MAG_W-1:0]     sel_mag;
        logic [MSG_WIDTH-1:0] pos_val;
        logic [MSG_WIDTH-1:0] neg_val;

        assign sel_mag = (idx3_reg == IDX_W'(i)) ? amin1_reg : amin0_reg;
        assign pos_val = {1'b0, sel_mag};
        assign neg_val = MSG_WIDTH'(~pos_val) + MSG_WIDTH'(1);
        assign tdata_next[i*MSG_WIDTH +: MSG_WIDTH] =
            !act3_reg[i] ? '0 : (sgn3_reg[i] ? neg_val : pos_val);
    end

    if (TDATA_W > USED_W) begin : g_pad
        assign tdata_next[TDATA_W-1:USED_W] = '0;
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            tdata_reg <= tdata_next;
        end
    end

    assign m_tdata  = tdata_reg;
    assign m_tvalid = v4_reg;

    // merged minima are ordered
    `LCN_ASSERT_NOW(a_min_order, v2_reg, min0_reg <= min1_reg)
    // the minimum lane is always an active lane
    `LCN_ASSERT_NOW(a_idx_active, v2_reg, act2_reg[idx2_reg])
    // a stalled stage keeps its row
    `LCN_ASSERT_NEXT(a_stall_keep, v3_reg && !en4, v3_reg)
    // a full pipeline with a stalled receiver takes nothing in
    `LCN_ASSERT_NOW(a_full_block, v1_reg && v2_reg && v3_reg && v4_reg && !m_tready,
                    !s_tready)

endmodule

// ===== hdl/ldpc_cn_lane.sv =====
module ldpc_cn_lane
    import ldpc_cn_pkg::*;
#(
    parameter int MSG_WIDTH = MSG_WIDTH_DEF
) (
    input  logic signed [MSG_WIDTH-1:0] msg,
    input  logic                        active,
    output logic        [MSG_WIDTH-1:0] mag,
    output logic                        neg
);

    localparam logic [MSG_WIDTH-1:0] MAG_NONE = {1'b1, {(MSG_WIDTH-1){1'b0}}};
    localparam logic [MSG_WIDTH-1:0] MAG_MAX  = {1'b0, {(MSG_WIDTH-1){1'b1}}};

    logic [MSG_WIDTH-1:0] negated;

    // two's complement magnitude, most negative code saturates
    assign negated = MSG_WIDTH'(~msg) + MSG_WIDTH'(1);

    always_comb begin
        if (!active) begin
            mag = MAG_NONE;
            neg = 1'b0;
        end else if (msg[MSG_WIDTH-1]) begin
            mag = (negated == MAG_NONE) ? MAG_MAX : negated;
            neg = 1'b1;
        end else begin
            mag = msg;
            neg = 1'b0;
        end
    end

endmodule

// ===== hdl/ldpc_cn_merge.sv =====
module ldpc_cn_merge
    import ldpc_cn_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int MSG_WIDTH  = MSG_WIDTH_DEF,
    localparam int IDX_W     = $clog2(MAX_DEGREE),
    localparam int MAG_W     = MSG_WIDTH - 1
) (
    input  logic [MSG_WIDTH-1:0] mag [MAX_DEGREE],
    output logic [MAG_W-1:0]     min0,
    output logic [MAG_W-1:0]     min1,
    output logic [IDX_W-1:0]     idx
);

    localparam int LEVELS = IDX_W;
    localparam int NPAD   = 1 << LEVELS;
    localparam logic [MSG_WIDTH-1:0] MAG_NONE = {1'b1, {(MSG_WIDTH-1){1'b0}}};

    logic [MSG_WIDTH-1:0] n_min0 [LEVELS+1][NPAD];
    logic [MSG_WIDTH-1:0] n_min1 [LEVELS+1][NPAD];
    logic [IDX_W-1:0]     n_idx  [LEVELS+1][NPAD];

    // leaves: one per lane, padding lanes never win
    for (genvar k = 0; k < NPAD; k++) begin : g_leaf
        if (k < MAX_DEGREE) begin : g_real
            assign n_min0[0][k] = mag[k];
        end else begin : g_pad
            assign n_min0[0][k] = MAG_NONE;
        end
        assign n_min1[0][k] = MAG_NONE;
        assign n_idx[0][k]  = IDX_W'(k);
    end

    // pairwise merge, the left node holds the lower lanes so ties keep the left index
    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        for (genvar k = 0; k < (NPAD >> (l + 1)); k++) begin : g_node
            logic right_wins;
            assign right_wins = n_min0[l][2*k+1] < n_min0[l][2*k];
            always_comb begin
                if (right_wins) begin
                    n_min0[l+1][k] = n_min0[l][2*k+1];
                    n_idx[l+1][k]  = n_idx[l][2*k+1];
                    n_min1[l+1][k] = (n_min0[l][2*k] < n_min1[l][2*k+1]) ?
                                     n_min0[l][2*k] : n_min1[l][2*k+1];
                end else begin
                    n_min0[l+1][k] = n_min0[l][2*k];
                    n_idx[l+1][k]  = n_idx[l][2*k];
                    n_min1[l+1][k] = (n_min0[l][2*k+1] < n_min1[l][2*k]) ?
                                     n_min0[l][2*k+1] : n_min1[l][2*k];
                end
            end
        end
    end

    // at least two lanes are active, so both minima fit the magnitude width
    assign min0 = n_min0[LEVELS][0][MAG_W-1:0];
    assign min1 = n_min1[LEVELS][0][MAG_W-1:0];
    assign idx  = n_idx[LEVELS][0];

endmodule

// ===== hdl/ldpc_cn_adjust.sv =====
module ldpc_cn_adjust
    import ldpc_cn_pkg::*;
#(
    parameter int MSG_WIDTH = MSG_WIDTH_DEF,
    localparam int MAG_W    = MSG_WIDTH - 1
) (
    input  cnu_cfg_t         cfg,
    input  logic [MAG_W-1:0] mag_in,
    output logic [MAG_W-1:0] mag_out
);

    localparam int PW = MAG_W + NORM_W;
    localparam int CW = (MAG_W > OFF_W) ? MAG_W : OFF_W;

    logic [PW-1:0] prod;
    logic [CW-1:0] mag_ext;
    logic [CW-1:0] off_ext;
    logic [CW-1:0] diff;

    // q0.8 scaling, truncated
    assign prod = PW'(mag_in) * PW'(cfg.norm_factor);

    // offset with floor at zero
    assign mag_ext = CW'(mag_in);
    assign off_ext = CW'(cfg.offset_value);
    assign diff    = mag_ext - off_ext;

    always_comb begin
        unique case (cfg.mode)
            MODE_NORM:   mag_out = prod[PW-1:NORM_W];
            MODE_OFFSET: mag_out = (mag_ext > off_ext) ? diff[MAG_W-1:0] : '0;
            default:     mag_out = mag_in;
        endcase
    end

endmodule
